FILE: src/winograd_output_transform_2x2_3x3_macros.svh
// ----------------------------------------------------------------------------
// winograd output transform assertion macros
// shared property forms for the checks of the output transform
// ----------------------------------------------------------------------------
`ifndef WINOGRAD_OUTPUT_TRANSFORM_2X2_3X3_MACROS_SVH
`define WINOGRAD_OUTPUT_TRANSFORM_2X2_3X3_MACROS_SVH

// same-cycle implication
`define WOT_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define WOT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/wot_pkg.sv
// ----------------------------------------------------------------------------
// winograd output transform package
// widths, register indexes and shared types of the output transform
// ----------------------------------------------------------------------------
package wot_pkg;

   localparam int IN_BITS  = 24;
   localparam int OUT_BITS = 28;
   localparam int EXT_BITS = (IN_BITS > OUT_BITS) ? IN_BITS : OUT_BITS;

   localparam int QDEPTH    = 2;
   localparam int QPTR_BITS = $clog2(QDEPTH);
   localparam int QLVL_BITS = $clog2(QDEPTH + 1);

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 1;

   localparam logic [CSR_INDEX_BITS-1:0] REG_BIAS_ENABLE = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_CROP_BOTTOM = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_CROP_RIGHT  = 2'd2;

   typedef logic signed [IN_BITS-1:0]  in_type;
   typedef logic signed [OUT_BITS-1:0] sum_type;

   typedef struct packed {
      logic bias_enable;
      logic crop_bottom;
      logic crop_right;
   } cfg_type;

   typedef struct packed {
      logic [3:0][OUT_BITS-1:0] sums;
      logic [OUT_BITS-1:0]      bias;
      logic                     crop_bottom;
      logic                     crop_right;
   } tile_type;

   typedef struct packed {
      logic                 head_valid;
      logic [QLVL_BITS-1:0] level;
   } q_status_type;

   // sign extend or wrap an input element to the sum width
   function automatic sum_type ext_in(input in_type v);
      logic signed [EXT_BITS-1:0] w;
      w = EXT_BITS'(v);
      return w[OUT_BITS-1:0];
   endfunction

endpackage

FILE: src/wot_front.sv
// ----------------------------------------------------------------------------
// winograd output transform front end
// takes tile rows, forms row sums and folds them into the four tile sums
// ----------------------------------------------------------------------------
module wot_front import wot_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  in_type       req_elem_first,
   input  in_type       req_elem_second,
   input  in_type       req_elem_third,
   input  in_type       req_elem_fourth,
   input  in_type       req_bias_value,
   input  cfg_type      cfg,
   input  q_status_type q_status,
   output logic         q_push,
   output tile_type     q_push_data
);

   localparam logic [1:0] ROW_FIRST  = 2'd0;
   localparam logic [1:0] ROW_SECOND = 2'd1;
   localparam logic [1:0] ROW_THIRD  = 2'd2;
   localparam logic [1:0] ROW_LAST   = 2'd3;

   logic [1:0] row_ff, row_in;
   logic       s1_valid_ff, s1_valid_in;
   logic [1:0] s1_row_ff;
   sum_type    s1_p_ff, s1_q_ff, s1_bias_ff;
   sum_type    sums_ff [4];
   sum_type    sums_in [4];
   logic       req_xfer;
   logic       s1_last;
   logic [QLVL_BITS:0] reserved;

   // a last row needs a queue slot, counting one still in stage one
   assign s1_last  = s1_valid_ff && (s1_row_ff == ROW_LAST);
   assign reserved = {1'b0, q_status.level} + (QLVL_BITS+1)'(s1_last);
   assign req_stall = (row_ff == ROW_LAST) && (reserved >= (QLVL_BITS+1)'(QDEPTH));
   assign req_xfer  = req_valid && !req_stall;

   assign row_in      = req_xfer ? row_ff + 2'd1 : row_ff;
   assign s1_valid_in = req_xfer;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff      <= ROW_FIRST;
         s1_valid_ff <= 1'b0;
      end else begin
         row_ff      <= row_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   // row sums a+b+c and b-c-d
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_row_ff  <= row_ff;
         s1_p_ff    <= ext_in(req_elem_first) + ext_in(req_elem_second)
                       + ext_in(req_elem_third);
         s1_q_ff    <= ext_in(req_elem_second) - ext_in(req_elem_third)
                       - ext_in(req_elem_fourth);
         s1_bias_ff <= cfg.bias_enable ? ext_in(req_bias_value) : '0;
      end
   end

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         sums_in[i] = sums_ff[i];
      end
      unique case (s1_row_ff)
         ROW_FIRST: begin
            sums_in[0] = s1_p_ff;
            sums_in[1] = s1_q_ff;
            sums_in[2] = '0;
            sums_in[3] = '0;
         end
         ROW_SECOND: begin
            sums_in[0] = sums_ff[0] + s1_p_ff;
            sums_in[1] = sums_ff[1] + s1_q_ff;
            sums_in[2] = sums_ff[2] + s1_p_ff;
            sums_in[3] = sums_ff[3] + s1_q_ff;
         end
         ROW_THIRD: begin
            sums_in[0] = sums_ff[0] + s1_p_ff;
            sums_in[1] = sums_ff[1] + s1_q_ff;
            sums_in[2] = sums_ff[2] - s1_p_ff;
            sums_in[3] = sums_ff[3] - s1_q_ff;
         end
         default: begin
            sums_in[2] = sums_ff[2] - s1_p_ff;
            sums_in[3] = sums_ff[3] - s1_q_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         for (int i = 0; i < 4; i++) begin
            sums_ff[i] <= sums_in[i];
         end
      end
   end

   assign q_push = s1_last;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         q_push_data.sums[i] = sums_in[i];
      end
      q_push_data.bias        = s1_bias_ff;
      q_push_data.crop_bottom = cfg.crop_bottom;
      q_push_data.crop_right  = cfg.crop_right;
   end

endmodule

FILE: src/wot_queue.sv
// ----------------------------------------------------------------------------
// winograd output transform tile queue
// short fifo of finished tiles between the front end and the cell emitter
// ----------------------------------------------------------------------------
module wot_queue import wot_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  tile_type     push_data,
   input  logic         pop,
   output tile_type     head,
   output q_status_type status
);

   tile_type               entries_ff [QDEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QLVL_BITS-1:0]   level_ff, level_in;

   function automatic logic [QPTR_BITS-1:0] ptr_next(input logic [QPTR_BITS-1:0] p);
      return (p == QPTR_BITS'(QDEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      level_in  = level_ff;
      if (push && !pop) begin
         level_in = level_ff + 1'b1;
      end else if (pop && !push) begin
         level_in = level_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head              = entries_ff[rd_ptr_ff];
   assign status.head_valid = (level_ff != '0);
   assign status.level      = level_ff;

endmodule

FILE: src/wot_back.sv
// ----------------------------------------------------------------------------
// winograd output transform cell emitter
// walks the surviving cells of the head tile and drives the result register
// ----------------------------------------------------------------------------
module wot_back import wot_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  tile_type      head,
   input  q_status_type  q_status,
   output logic          q_pop,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output logic          rsp_cell_row,
   output logic          rsp_cell_col,
   output sum_type       rsp_cell_value,
   output logic          rsp_tile_last
);

   logic    row_ff, row_in;
   logic    col_ff, col_in;
   logic    valid_ff, valid_in;
   logic    out_row_ff, out_col_ff, out_last_ff;
   sum_type out_value_ff;
   logic    emit;
   logic    last;

   assign emit = q_status.head_valid && (!valid_ff || !rsp_stall);
   assign last = (row_ff || head.crop_bottom) && (col_ff || head.crop_right);
   assign q_pop = emit && last;

   // next cell in row-major order, skipping the padded row and column
   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (emit) begin
         if (last) begin
            row_in = 1'b0;
            col_in = 1'b0;
         end else if (col_ff || head.crop_right) begin
            row_in = 1'b1;
            col_in = 1'b0;
         end else begin
            col_in = 1'b1;
         end
      end
      valid_in = emit ? 1'b1 : (valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff   <= 1'b0;
         col_ff   <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         row_ff   <= row_in;
         col_ff   <= col_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         out_row_ff   <= row_ff;
         out_col_ff   <= col_ff;
         out_last_ff  <= last;
         out_value_ff <= head.sums[{row_ff, col_ff}] + head.bias;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_cell_row   = out_row_ff;
   assign rsp_cell_col   = out_col_ff;
   assign rsp_cell_value = out_value_ff;
   assign rsp_tile_last  = out_last_ff;

endmodule

FILE: src/winograd_output_transform_2x2_3x3.sv
// ----------------------------------------------------------------------------
// winograd f(2x2,3x3) output transform
// Takes one row of a 4x4 winograd-domain tile per transfer and, after the
// fourth row, returns the surviving cells of the 2x2 output tile in row-major
// order with the last one marked. A row is taken every cycle unless req_stall
// is high; results leave at one per cycle unless rsp_stall is high, and a
// tile of four rows yields up to four results. The first result of a tile
// passes through the row-sum stage and the tile queue to the result register.
// A two-entry tile queue lets rows keep flowing while results are stalled;
// a last row waits only while the queue holds two tiles.
// ----------------------------------------------------------------------------
`include "winograd_output_transform_2x2_3x3_macros.svh"

module winograd_output_transform_2x2_3x3 import wot_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  in_type                    req_elem_first,
   input  in_type                    req_elem_second,
   input  in_type                    req_elem_third,
   input  in_type                    req_elem_fourth,
   input  in_type                    req_bias_value,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_cell_row,
   output logic                      rsp_cell_col,
   output sum_type                   rsp_cell_value,
   output logic                      rsp_tile_last,
   input  logic                      csr_write,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data
);

   cfg_type      cfg_ff, cfg_in;
   logic         q_push;
   logic         q_pop;
   tile_type     q_push_data;
   tile_type     q_head;
   q_status_type q_status;
   logic         q_room;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_BIAS_ENABLE: cfg_in.bias_enable = csr_data[0];
            REG_CROP_BOTTOM: cfg_in.crop_bottom = csr_data[0];
            REG_CROP_RIGHT:  cfg_in.crop_right  = csr_data[0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   wot_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_elem_first  (req_elem_first),
      .req_elem_second (req_elem_second),
      .req_elem_third  (req_elem_third),
      .req_elem_fourth (req_elem_fourth),
      .req_bias_value  (req_bias_value),
      .cfg             (cfg_ff),
      .q_status        (q_status),
      .q_push          (q_push),
      .q_push_data     (q_push_data)
   );

   wot_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .head      (q_head),
      .status    (q_status)
   );

   wot_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (q_head),
      .q_status       (q_status),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_cell_row   (rsp_cell_row),
      .rsp_cell_col   (rsp_cell_col),
      .rsp_cell_value (rsp_cell_value),
      .rsp_tile_last  (rsp_tile_last)
   );

   assign q_room = (q_status.level < QLVL_BITS'(QDEPTH)) || q_pop;

   `WOT_ASSERT_IMPLY(a_queue_no_overflow, clock, reset, q_push, q_room, "tile queue overflow")
   `WOT_ASSERT_IMPLY(a_queue_no_underflow, clock, reset, q_pop, q_status.head_valid, "tile queue underflow")
   `WOT_ASSERT_NEXT(a_reset_clears_output, clock, 1'b0, reset, !rsp_valid, "result valid after reset")

endmodule

FILE: tb/wot_output_check.sv
// ----------------------------------------------------------------------------
// winograd output transform checker
// Watches the row, result and register ports of the output transform, keeps
// its own tile sums and settings, works out the output cells each fourth row
// produces and compares every result transfer with the oldest pending cell.
// ----------------------------------------------------------------------------
module wot_output_check import wot_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_stall,
   input  in_type                    req_elem_first,
   input  in_type                    req_elem_second,
   input  in_type                    req_elem_third,
   input  in_type                    req_elem_fourth,
   input  in_type                    req_bias_value,
   input  logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  logic                      rsp_cell_row,
   input  logic                      rsp_cell_col,
   input  sum_type                   rsp_cell_value,
   input  logic                      rsp_tile_last,
   input  logic                      csr_write,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data,
   output int                        fail_count,
   output int                        cells_outstanding,
   output int                        cells_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic    row;
      logic    col;
      sum_type value;
      logic    last;
   } out_cell_type;

   out_cell_type pending_cells[$];
   out_cell_type oldest;
   logic [1:0]   row_count;
   sum_type      tile_acc [4];
   cfg_type      settings;

   initial begin
      fail_count        = 0;
      cells_outstanding = 0;
      cells_checked     = 0;
   end

   function automatic sum_type widen(input in_type v);
      sum_type w;
      w = OUT_BITS'(v);
      return w;
   endfunction

   // fold one tile row into the sums and queue the cells of a finished tile
   task automatic fold_row(input in_type a, input in_type b, input in_type c,
                           input in_type d, input in_type bias);
      sum_type      p;
      sum_type      q;
      int           rows;
      int           cols;
      out_cell_type oc;
      p = widen(a) + widen(b) + widen(c);
      q = widen(b) - widen(c) - widen(d);
      case (row_count)
         2'd0: begin
            tile_acc[0] = p;
            tile_acc[1] = q;
            tile_acc[2] = '0;
            tile_acc[3] = '0;
         end
         2'd1: begin
            tile_acc[0] += p;
            tile_acc[1] += q;
            tile_acc[2] += p;
            tile_acc[3] += q;
         end
         2'd2: begin
            tile_acc[0] += p;
            tile_acc[1] += q;
            tile_acc[2] -= p;
            tile_acc[3] -= q;
         end
         default: begin
            tile_acc[2] -= p;
            tile_acc[3] -= q;
            rows = settings.crop_bottom ? 1 : 2;
            cols = settings.crop_right ? 1 : 2;
            for (int i = 0; i < rows; i++) begin
               for (int j = 0; j < cols; j++) begin
                  oc.row   = i[0];
                  oc.col   = j[0];
                  oc.value = tile_acc[i * 2 + j];
                  if (settings.bias_enable) begin
                     oc.value += widen(bias);
                  end
                  oc.last  = (i == rows - 1) && (j == cols - 1);
                  pending_cells.push_back(oc);
               end
            end
         end
      endcase
      row_count = row_count + 2'd1;
   endtask

   task automatic compare_field(input string field, input longint want, input longint got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
         fail_count = fail_count + 1;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         pending_cells.delete();
         row_count = 2'd0;
         settings  = '0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_cells.size() == 0) begin
               $display("%0t: unexpected result transfer, row %0d col %0d value %0d",
                        $time, rsp_cell_row, rsp_cell_col, rsp_cell_value);
               fail_count = fail_count + 1;
            end else begin
               oldest = pending_cells.pop_front();
               compare_field("cell_row", oldest.row, rsp_cell_row);
               compare_field("cell_col", oldest.col, rsp_cell_col);
               compare_field("cell_value", longint'(oldest.value), longint'(rsp_cell_value));
               compare_field("tile_last", oldest.last, rsp_tile_last);
               cells_checked <= cells_checked + 1;
            end
         end
         if (csr_write) begin
            case (csr_index)
               REG_BIAS_ENABLE: settings.bias_enable = csr_data[0];
               REG_CROP_BOTTOM: settings.crop_bottom = csr_data[0];
               REG_CROP_RIGHT:  settings.crop_right  = csr_data[0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            fold_row(req_elem_first, req_elem_second, req_elem_third, req_elem_fourth,
                     req_bias_value);
         end
      end
      cells_outstanding <= pending_cells.size();
   end

endmodule

FILE: tb/winograd_output_transform_2x2_3x3_tb.sv
// ----------------------------------------------------------------------------
// winograd output transform testbench
// Streams tile rows into the output transform under every padding and bias
// setting, first a few directed extreme tiles and then random tiles, with
// random gaps on the row side and random stalls on the result side, one
// long result hold-off that backs the block up, and a quiet-cycle watchdog.
// ----------------------------------------------------------------------------
module winograd_output_transform_2x2_3x3_tb;
   import wot_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int     WATCHDOG_LIMIT   = 1000;
   localparam int     HOLD_CYCLES      = 150;
   localparam int     PHASES           = 10;
   localparam int     TILES_PER_PHASE  = 5;
   localparam int     PRESSURE_PHASE   = 5;
   localparam int     DRAIN_CYCLES     = 8;
   localparam in_type ELEM_MAX         = in_type'({1'b0, {(IN_BITS - 1){1'b1}}});
   localparam in_type ELEM_MIN         = in_type'({1'b1, {(IN_BITS - 1){1'b0}}});

   typedef enum {TILE_ZERO, TILE_HIGH, TILE_LOW, TILE_RANDOM} tile_kind_type;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   in_type                    req_elem_first;
   in_type                    req_elem_second;
   in_type                    req_elem_third;
   in_type                    req_elem_fourth;
   in_type                    req_bias_value;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic                      rsp_cell_row;
   logic                      rsp_cell_col;
   sum_type                   rsp_cell_value;
   logic                      rsp_tile_last;
   logic                      csr_write;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_data;

   int fail_count;
   int cells_outstanding;
   int cells_checked;
   int sender_gap_max;
   int receiver_stall_max;
   bit hold_request;
   int rows_sent;
   int tiles_sent;
   int settings_used;
   int quiet_cycles;

   winograd_output_transform_2x2_3x3 DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_elem_first  (req_elem_first),
      .req_elem_second (req_elem_second),
      .req_elem_third  (req_elem_third),
      .req_elem_fourth (req_elem_fourth),
      .req_bias_value  (req_bias_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_cell_row    (rsp_cell_row),
      .rsp_cell_col    (rsp_cell_col),
      .rsp_cell_value  (rsp_cell_value),
      .rsp_tile_last   (rsp_tile_last),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   wot_output_check tile_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_elem_first    (req_elem_first),
      .req_elem_second   (req_elem_second),
      .req_elem_third    (req_elem_third),
      .req_elem_fourth   (req_elem_fourth),
      .req_bias_value    (req_bias_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_cell_row      (rsp_cell_row),
      .rsp_cell_col      (rsp_cell_col),
      .rsp_cell_value    (rsp_cell_value),
      .rsp_tile_last     (rsp_tile_last),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .fail_count        (fail_count),
      .cells_outstanding (cells_outstanding),
      .cells_checked     (cells_checked)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   function automatic in_type pick_elem();
      case ($urandom_range(0, 7))
         0: return ELEM_MAX;
         1: return ELEM_MIN;
         2: return '0;
         3: return '1;
         default: return in_type'($urandom);
      endcase
   endfunction

   task automatic send_row(input in_type a, input in_type b, input in_type c,
                           input in_type d, input in_type bias);
      int gap;
      gap = $urandom_range(0, sender_gap_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_elem_first  <= a;
      req_elem_second <= b;
      req_elem_third  <= c;
      req_elem_fourth <= d;
      req_bias_value  <= bias;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      rows_sent++;
   endtask

   // rows 0 to 2 carry a random bias that the block must ignore
   task automatic send_tile(input tile_kind_type kind, input in_type last_bias);
      in_type e [4];
      for (int r = 0; r < 4; r++) begin
         case (kind)
            TILE_ZERO:   e = '{'0, '0, '0, '0};
            TILE_HIGH:   e = '{ELEM_MAX, ELEM_MAX, ELEM_MAX, ELEM_MIN};
            TILE_LOW:    e = '{ELEM_MIN, ELEM_MIN, ELEM_MIN, ELEM_MAX};
            default:     e = '{pick_elem(), pick_elem(), pick_elem(), pick_elem()};
         endcase
         send_row(e[0], e[1], e[2], e[3], (r == 3) ? last_bias : pick_elem());
      end
      tiles_sent++;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (cells_outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx, input logic val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_setting(input logic bias_on, input logic pad_b, input logic pad_r);
      settle();
      write_reg(REG_BIAS_ENABLE, bias_on);
      write_reg(REG_CROP_BOTTOM, pad_b);
      write_reg(REG_CROP_RIGHT, pad_r);
      settings_used++;
   endtask

   // result side: random stall before each transfer, one long hold on request
   initial begin
      int n;
      rsp_stall <= 1'b0;
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            n = HOLD_CYCLES;
         end else begin
            n = $urandom_range(0, receiver_stall_max);
         end
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog expired with %0d cells outstanding", $time, cells_outstanding);
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      logic [2:0] combo;
      reset              <= 1'b1;
      req_valid          <= 1'b0;
      req_elem_first     <= '0;
      req_elem_second    <= '0;
      req_elem_third     <= '0;
      req_elem_fourth    <= '0;
      req_bias_value     <= '0;
      csr_write          <= 1'b0;
      csr_index          <= REG_BIAS_ENABLE;
      csr_data           <= '0;
      hold_request       = 1'b0;
      sender_gap_max     = 0;
      receiver_stall_max = 0;
      rows_sent          = 0;
      tiles_sent         = 0;
      settings_used      = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed tiles at the extremes, bias ignored while disabled
      send_tile(TILE_ZERO, '0);
      send_tile(TILE_HIGH, ELEM_MAX);
      send_tile(TILE_LOW, ELEM_MIN);
      apply_setting(1'b1, 1'b1, 1'b1);
      send_tile(TILE_HIGH, ELEM_MAX);
      apply_setting(1'b1, 1'b0, 1'b1);
      send_tile(TILE_LOW, ELEM_MIN);
      apply_setting(1'b1, 1'b1, 1'b0);
      send_tile(TILE_HIGH, ELEM_MIN);

      // random tiles, every setting at least once
      for (int ph = 0; ph < PHASES; ph++) begin
         combo = (ph < 8) ? 3'(ph) : 3'($urandom);
         sender_gap_max     = ($urandom_range(0, 3) == 0) ? 0 : 12;
         receiver_stall_max = ($urandom_range(0, 3) == 0) ? 0 : 12;
         apply_setting(combo[0], combo[1], combo[2]);
         if (ph == PRESSURE_PHASE) begin
            sender_gap_max = 0;
            hold_request   = 1'b1;
         end
         repeat (TILES_PER_PHASE) send_tile(TILE_RANDOM, pick_elem());
      end
      settle();

      $display("sent %0d tile rows in %0d tiles under %0d register settings",
               rows_sent, tiles_sent, settings_used);
      $display("checked %0d output cells, %0d mismatches", cells_checked, fail_count);
      if (fail_count == 0 && cells_outstanding == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

FILE: sim.f
+incdir+src
src/wot_pkg.sv
src/wot_front.sv
src/wot_queue.sv
src/wot_back.sv
src/winograd_output_transform_2x2_3x3.sv
tb/wot_output_check.sv
tb/winograd_output_transform_2x2_3x3_tb.sv
